>>> src/rcbd_pkg.sv
// Shared constants and byte codes for the remote command byte decoder.
// Depends on nothing; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package rcbd_pkg;

  // Default number of bytes kept per parameter frame, opening brace included.
  localparam int unsigned FrameCapacityDef = 64;

  // Widths of the stream payloads.
  localparam int unsigned InDataW  = 8;
  localparam int unsigned OutDataW = 48;
  localparam int unsigned ValueW   = 32;

  // Turn mode control bytes.
  localparam logic [7:0] ByteTurnOn   = 8'h4B;
  localparam logic [7:0] ByteTurnOffI = 8'h49;
  localparam logic [7:0] ByteTurnOffJ = 8'h4A;

  // Direction bytes.
  localparam logic [7:0] ByteDirBase  = 8'h40;
  localparam logic [7:0] ByteDirFirst = 8'h41;
  localparam logic [7:0] ByteDirLast  = 8'h48;
  localparam logic [7:0] ByteDirFwd   = 8'h41;
  localparam logic [7:0] ByteDirBack  = 8'h45;
  localparam logic [7:0] ByteRawLast  = 8'h08;
  localparam logic [7:0] ByteSteerR   = 8'h43;
  localparam logic [7:0] ByteSteerL   = 8'h47;

  // Frame bytes.
  localparam logic [7:0] ByteOpen     = 8'h7B;
  localparam logic [7:0] ByteClose    = 8'h7D;
  localparam logic [7:0] ByteReport   = 8'h50;
  localparam logic [7:0] ByteSave     = 8'h57;
  localparam logic [7:0] ByteNoWrite  = 8'h23;
  localparam logic [7:0] AsciiZero    = 8'h30;
  localparam logic [7:0] AsciiSix     = 8'h36;

endpackage

`default_nettype wire

>>> src/rcbd_acc.sv
// Decimal accumulation step: value * 10 + (byte - '0'), clamped to signed 32 bits.
// Depends on rcbd_pkg for the ASCII zero offset and the value width.
`timescale 1ns / 1ps
`default_nettype none

module rcbd_acc
  import rcbd_pkg::*;
(
  input  wire logic signed [ValueW-1:0] acc_i,
  input  wire logic        [7:0]        byte_i,
  output logic      signed [ValueW-1:0] acc_o
);

  localparam int unsigned WideW = ValueW + 5;
  localparam logic signed [WideW-1:0] WideMax = WideW'(signed'({1'b0, {(ValueW-1){1'b1}}}));
  localparam logic signed [WideW-1:0] WideMin = -WideMax - WideW'(1);

  logic signed [WideW-1:0] acc_wide;
  logic signed [WideW-1:0] times_ten;
  logic signed [WideW-1:0] digit;
  logic signed [WideW-1:0] sum;

  // Times ten as two shifts, then the digit offset; the wide sum cannot overflow.
  always_comb begin
    acc_wide  = WideW'(acc_i);
    times_ten = (acc_wide <<< 3) + (acc_wide <<< 1);
    digit     = WideW'($signed({1'b0, byte_i})) - WideW'($signed({1'b0, AsciiZero}));
    sum       = times_ten + digit;
    if (sum > WideMax) begin
      acc_o = WideMax[ValueW-1:0];
    end else if (sum < WideMin) begin
      acc_o = WideMin[ValueW-1:0];
    end else begin
      acc_o = sum[ValueW-1:0];
    end
  end

endmodule

`default_nettype wire

>>> src/remote_command_byte_decoder_top.sv
// Remote command byte decoder, top level.
// The result of an accepted byte is registered and shows on the master side
// in the next cycle. Throughput: one byte per cycle while results are taken;
// the frame state and the result register are both updated at the accepting
// edge, and the result register frees itself in the cycle the result is taken.
// Reset: all control and frame state clears to zero, no result is pending.
`timescale 1ns / 1ps
`default_nettype none

module remote_command_byte_decoder_top
  import rcbd_pkg::*;
#(
  parameter int unsigned FrameCapacity = FrameCapacityDef
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // Slave side: tdata = rx_byte[7:0]; tuser = dir_hold[0].
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  input  wire logic [InDataW-1:0]  s_axis_tdata,
  input  wire logic                s_axis_tuser,
  // Master side: tdata = turn_mode[0], direction[4:1], steer_left[5],
  // steer_right[6], param_write[7], param_select[10:8], param_value[42:11],
  // report_request[43], flash_save_request[44], zero pad[47:45].
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  output logic [OutDataW-1:0]      m_axis_tdata
);

  localparam int unsigned CntW = $clog2(FrameCapacity + 1);

  // Persistent state.
  logic                     collecting_q, collecting_d;
  logic [CntW-1:0]          cnt_q, cnt_d;
  logic [7:0]               id_q, id_d;
  logic [7:0]               fourth_q, fourth_d;
  logic signed [ValueW-1:0] acc_q, acc_d;
  logic                     turn_q, turn_d;
  logic [3:0]               dir_q, dir_d;
  logic                     left_q, left_d;
  logic                     right_q, right_d;

  // Result register.
  logic                     out_valid_q;
  logic                     pw_q, pw_d;
  logic [2:0]               psel_q, psel_d;
  logic signed [ValueW-1:0] pval_q, pval_d;
  logic                     rep_q, rep_d;
  logic                     fsave_q, fsave_d;

  logic                     accept;
  logic [7:0]               rx_byte;
  logic                     dir_hold;
  logic                     closing;
  logic signed [ValueW-1:0] acc_step;

  assign rx_byte       = s_axis_tdata;
  assign dir_hold      = s_axis_tuser;
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign closing       = (rx_byte == ByteClose);

  rcbd_acc u_acc (
    .acc_i  (acc_q),
    .byte_i (rx_byte),
    .acc_o  (acc_step)
  );

  // Turn mode, drive direction and steer flags.
  always_comb begin
    turn_d  = turn_q;
    dir_d   = dir_q;
    left_d  = left_q;
    right_d = right_q;
    if (rx_byte == ByteTurnOn) begin
      turn_d = 1'b1;
    end else if (rx_byte == ByteTurnOffI || rx_byte == ByteTurnOffJ) begin
      turn_d = 1'b0;
    end
    if (!dir_hold) begin
      if (!turn_d) begin
        if (rx_byte >= ByteDirFirst && rx_byte <= ByteDirLast) begin
          dir_d = 4'(rx_byte - ByteDirBase);
        end else if (rx_byte <= ByteRawLast) begin
          dir_d = rx_byte[3:0];
        end else begin
          dir_d = 4'd0;
        end
      end else begin
        left_d  = (rx_byte == ByteSteerL);
        right_d = (rx_byte == ByteSteerR);
        if (rx_byte == ByteDirFwd || rx_byte == ByteDirBack) begin
          dir_d = 4'(rx_byte - ByteDirBase);
        end else begin
          dir_d = 4'd0;
        end
      end
    end
  end

  // Frame collection and the decision taken at the closing brace.
  always_comb begin
    collecting_d = collecting_q || (rx_byte == ByteOpen);
    cnt_d        = cnt_q;
    id_d         = id_q;
    fourth_d     = fourth_q;
    acc_d        = acc_q;
    pw_d         = 1'b0;
    psel_d       = 3'd0;
    pval_d       = '0;
    rep_d        = 1'b0;
    fsave_d      = 1'b0;
    if (closing) begin
      if (fourth_q == ByteReport) begin
        rep_d = 1'b1;
      end else if (fourth_q == ByteSave) begin
        fsave_d = 1'b1;
      end else if (id_q != ByteNoWrite && id_q >= AsciiZero && id_q <= AsciiSix) begin
        pw_d   = 1'b1;
        psel_d = 3'(id_q - AsciiZero);
        pval_d = acc_q;
      end
      collecting_d = 1'b0;
      cnt_d        = '0;
      id_d         = 8'd0;
      fourth_d     = 8'd0;
      acc_d        = '0;
    end else if (collecting_d && cnt_q < CntW'(FrameCapacity)) begin
      if (cnt_q == CntW'(1)) begin
        id_d = rx_byte;
      end
      if (cnt_q == CntW'(3)) begin
        fourth_d = rx_byte;
      end
      if (cnt_q >= CntW'(3)) begin
        acc_d = acc_step;
      end
      cnt_d = cnt_q + CntW'(1);
    end
  end

  // State and valid flag load at the accepting edge; valid clears once taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      collecting_q <= 1'b0;
      cnt_q        <= '0;
      id_q         <= 8'd0;
      fourth_q     <= 8'd0;
      acc_q        <= '0;
      turn_q       <= 1'b0;
      dir_q        <= 4'd0;
      left_q       <= 1'b0;
      right_q      <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (accept) begin
        collecting_q <= collecting_d;
        cnt_q        <= cnt_d;
        id_q         <= id_d;
        fourth_q     <= fourth_d;
        acc_q        <= acc_d;
        turn_q       <= turn_d;
        dir_q        <= dir_d;
        left_q       <= left_d;
        right_q      <= right_d;
        out_valid_q  <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q  <= 1'b0;
      end
    end
  end

  // Result payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      pw_q    <= pw_d;
      psel_q  <= psel_d;
      pval_q  <= pval_d;
      rep_q   <= rep_d;
      fsave_q <= fsave_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, fsave_q, rep_q, pval_q, psel_q, pw_q,
                          right_q, left_q, dir_q, turn_q};

  // A request and a parameter write never come from the same frame end.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !((rep_q && fsave_q) || (pw_q && (rep_q || fsave_q))))
    else $error("more than one frame action in one result");

  // Without a write the select and value fields read as zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !pw_q) |-> (psel_q == 3'd0 && pval_q == '0))
    else $error("select or value not zero without a write");

  // The frame count never passes the capacity.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(FrameCapacity))
    else $error("frame count beyond capacity");

  // Outside a frame nothing is stored.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !collecting_q |-> (cnt_q == '0 && id_q == 8'd0 && fourth_q == 8'd0 && acc_q == '0))
    else $error("frame store not clear outside a frame");

  // A closing brace always leaves the frame state cleared.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && closing) |=> (!collecting_q && cnt_q == '0))
    else $error("frame not cleared after closing brace");

endmodule

`default_nettype wire
